// ===== rtl/core/rse_pkg.sv =====
// Shared types, constants and GF(256) functions for the Reed-Solomon encoder.
package rse_pkg;

    localparam int PARITY_SYMBOLS = 16;
    localparam int DRAIN_W        = $clog2(PARITY_SYMBOLS + 1);
    localparam int COUNT_W        = 9;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [7:0] FIELD_POLY_LOW = 8'h1d;
    localparam logic [7:0] ALPHA = 8'h02;

    typedef logic [PARITY_SYMBOLS:0][7:0] gen_t;
    typedef logic [PARITY_SYMBOLS-1:0][7:0] cells_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       is_parity;
        logic       last;
        logic       too_long;
    } rse_item_t;

    typedef struct packed {
        logic full;
    } buf_status_t;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] x;
        logic [7:0] acc;
        x   = a;
        acc = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ x;
            end
            x = {x[6:0], 1'b0} ^ (x[7] ? FIELD_POLY_LOW : 8'h00);
        end
        return acc;
    endfunction

    function automatic gen_t build_gen();
        gen_t       g;
        logic [7:0] root;
        g    = '0;
        g[0] = 8'h01;
        root = 8'h01;
        for (int i = 0; i < PARITY_SYMBOLS; i++)
        begin
            for (int j = i + 1; j >= 1; j--)
            begin
                g[j] = g[j] ^ gf_mul(g[j-1], root);
            end
            root = gf_mul(root, ALPHA);
        end
        return g;
    endfunction

    localparam gen_t GEN = build_gen();

endpackage

// ===== rtl/core/rse_cell.sv =====
// One stage of the parity division register: neighbor value plus feedback times a coefficient.
module rse_cell
    import rse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [7:0] feedback,
    input  logic [7:0] upstream,
    input  logic [7:0] coef,
    output logic [7:0] value
);

    logic [7:0] value_reg;
    logic [7:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (advance)
        begin
            value_next = upstream ^ gf_mul(feedback, coef);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

// ===== rtl/core/rse_out_buf.sv =====
// Output register with one skid entry for the codeword channel.
module rse_out_buf
    import rse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  rse_item_t   push_item,
    output buf_status_t status,
    output logic        code_valid,
    input  logic        code_stall,
    output rse_item_t   out_item
);

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    rse_item_t out_item_reg, out_item_next;
    rse_item_t skid_item_reg, skid_item_next;
    logic      take;

    assign take = out_valid_reg & ~code_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_item_next   = out_item_reg;
        skid_item_next  = skid_item_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_item_next   = skid_item_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_item_next  = push_item;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_item_next  = push_item;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    assign status.full = skid_valid_reg;
    assign code_valid  = out_valid_reg;
    assign out_item    = out_item_reg;

endmodule

// ===== rtl/core/rs_systematic_encoder_unit.sv =====
// Top level of the systematic Reed-Solomon encoder over GF(256).
//
// Message bytes enter on the msg channel (msg_valid/msg_stall, data_byte,
// end_of_message), highest-order coefficient first. Every accepted byte is
// echoed on the code channel (code_valid/code_stall) through the output buffer, with
// is_parity low. A transaction that carries end_of_message is followed by
// PARITY_SYMBOLS parity bytes, highest-order first, one per cycle while the skid entry is free,
// with last high on the final one; too_long flags any symbol past the 255th of a
// codeword.
// Throughput: one message byte per cycle while msg_stall is low; after a byte with
// end_of_message the same row of cells shifts the parity out and msg_stall is held
// high meanwhile.
// Each symbol is registered in the output register, or in the skid entry while that is held.
// A stalled code channel fills one skid entry; msg_stall then rises until it
// drains, and nothing is dropped. Reset clears the cells, the symbol count
// and both output entries; the block is ready on the first cycle after.
module rs_systematic_encoder_unit
    import rse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       msg_valid,
    output logic       msg_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_message,
    output logic       code_valid,
    input  logic       code_stall,
    output logic [7:0] code_byte,
    output logic       is_parity,
    output logic       last,
    output logic       too_long
);

    logic [DRAIN_W-1:0] drain_cnt_reg, drain_cnt_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] bumped;
    cells_t             cell_value;
    logic [7:0]         feedback;
    logic               advance;
    logic               emit;
    logic               draining;
    logic               msg_take;
    rse_item_t          emit_item;
    rse_item_t          out_item;
    buf_status_t        buf_status;

    assign draining  = drain_cnt_reg != '0;
    assign msg_stall = draining | buf_status.full;
    assign msg_take  = msg_valid & ~msg_stall;
    assign bumped    = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_W'(1);

    always_comb
    begin
        emit           = 1'b0;
        advance        = 1'b0;
        feedback       = 8'h00;
        emit_item      = '0;
        drain_cnt_next = drain_cnt_reg;
        count_next     = count_reg;
        if (msg_take)
        begin
            emit      = 1'b1;
            advance   = 1'b1;
            feedback  = data_byte ^ cell_value[0];
            emit_item = '{code_byte: data_byte, is_parity: 1'b0, last: 1'b0,
                          too_long: bumped[COUNT_W-1]};
            count_next = bumped;
            if (end_of_message)
            begin
                drain_cnt_next = DRAIN_W'(PARITY_SYMBOLS);
            end
        end
        else if (draining && !buf_status.full)
        begin
            emit      = 1'b1;
            advance   = 1'b1;
            emit_item = '{code_byte: cell_value[0], is_parity: 1'b1,
                          last: (drain_cnt_reg == DRAIN_W'(1)),
                          too_long: bumped[COUNT_W-1]};
            drain_cnt_next = drain_cnt_reg - DRAIN_W'(1);
            count_next     = (drain_cnt_reg == DRAIN_W'(1)) ? '0 : bumped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_cnt_reg <= '0;
            count_reg     <= '0;
        end
        else
        begin
            drain_cnt_reg <= drain_cnt_next;
            count_reg     <= count_next;
        end
    end

    for (genvar i = 0; i < PARITY_SYMBOLS; i++)
    begin : g_cell
        logic [7:0] upstream;
        if (i == PARITY_SYMBOLS - 1)
        begin : g_tail
            assign upstream = 8'h00;
        end
        else
        begin : g_mid
            assign upstream = cell_value[i+1];
        end
        rse_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .feedback (feedback),
            .upstream (upstream),
            .coef     (GEN[i+1]),
            .value    (cell_value[i])
        );
    end

    rse_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (emit),
        .push_item  (emit_item),
        .status     (buf_status),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .out_item   (out_item)
    );

    assign code_byte = out_item.code_byte;
    assign is_parity = out_item.is_parity;
    assign last      = out_item.last;
    assign too_long  = out_item.too_long;

    a_drain_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        draining |-> msg_stall)
        else $error("message accepted during parity shift-out");

    a_last_is_parity: assert property (@(posedge clk) disable iff (!rst_n)
        (code_valid && last) |-> is_parity)
        else $error("last flag on a non-parity symbol");

    a_cells_clear_after_codeword: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_item.last) |=> (cell_value == '0 && count_reg == '0))
        else $error("encoder state not cleared after final parity");

    a_emit_only_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !buf_status.full)
        else $error("symbol produced while skid entry is occupied");

endmodule
